/* hdl/pec_pkg.sv */
// Shared types and constants for the polarization efficiency correction pipeline.
// Used by pec_coef, pec_num, pec_div and the top level; depends on nothing.
package pec_pkg;

   localparam int unsigned INT_W  = 32;
   localparam int unsigned EFF_W  = 18;
   localparam int unsigned COEF_W = 32;
   localparam int unsigned CSGN_W = 34;
   localparam int unsigned NUM_W  = 64;
   localparam int unsigned DEN_W  = 32;
   localparam int unsigned NLANE  = 4;

   typedef enum logic {
      MODE_FULL = 1'b0,
      MODE_TWO  = 1'b1
   } mode_type;

   typedef struct packed {
      logic signed [INT_W-1:0] int_pp;
      logic signed [INT_W-1:0] int_pa;
      logic signed [INT_W-1:0] int_ap;
      logic signed [INT_W-1:0] int_aa;
   } intens_type;

   // unsigned coefficients for four-channel mode, signed ones for two-channel mode
   typedef struct packed {
      intens_type                    ints;
      logic [COEF_W-1:0]             ppap;
      logic [COEF_W-1:0]             k_r;
      logic [COEF_W-1:0]             k_a;
      logic [COEF_W-1:0]             k_ar;
      logic [COEF_W-1:0]             pp;
      logic [COEF_W-1:0]             ap;
      logic [COEF_W-1:0]             c_aa;
      logic [COEF_W-1:0]             c_pr;
      logic [NLANE-1:0][CSGN_W-1:0]  m1_c;
      logic [DEN_W-1:0]              den;
   } coef_type;

   typedef struct packed {
      logic [NLANE-1:0][NUM_W-1:0] num;
      logic [DEN_W-1:0]            den;
   } num_type;

endpackage

/* hdl/pec_coef.sv */
// Coefficient pipeline: efficiency products, denominator and two-channel coefficients.
// Six register stages; depends on pec_pkg.
module pec_coef #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pec_pkg::mode_type    mode,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pec_pkg::intens_type  in_ints,
   input  logic [17:0]          in_rho,
   input  logic [17:0]          in_pp,
   input  logic [17:0]          in_alpha,
   input  logic [17:0]          in_ap,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pec_pkg::coef_type    out_coef
);

   localparam int NST = 6;
   localparam logic [31:0] ONE = 32'(64'(1) << FRAC_BITS);

   typedef struct packed {
      pec_pkg::intens_type ints;
      logic [17:0]         rho;
      logic [17:0]         pp;
      logic [17:0]         alpha;
      logic [17:0]         ap;
   } carry_type;

   // round half up to FRAC_BITS fraction bits, clip to 32 bits
   function automatic logic [31:0] rnd(input logic [63:0] p);
      logic [64:0] r;
      r = {1'b0, (p >> FRAC_BITS)} + 65'(p[FRAC_BITS-1]);
      rnd = (r > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   function automatic logic [31:0] csat34(input logic [33:0] x);
      csat34 = (x > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] ce;
   carry_type      car_ff [0:4];

   logic [35:0] s0_ppap_ff, s0_caa_ff, s0_cpr_ff, s0_ra_ff;
   logic [43:0] s0_d1_ff;
   logic [25:0] rho_one;

   logic [31:0] s1_ppap_ff, s1_caa_ff, s1_cpr_ff, s1_ra_ff, s1_d1_ff;

   logic [31:0] s2_ppap_ff, s2_caa_ff, s2_cpr_ff, s2_d1_ff, s2_sumc_ff;
   logic [49:0] s2_kr_ff, s2_ka_ff;
   logic [3:0][33:0] s2_m1_ff;
   logic [33:0] sumc_in;
   logic [32:0] c1_sum;

   logic [31:0] s3_ppap_ff, s3_caa_ff, s3_cpr_ff, s3_d1_ff, s3_kr_ff, s3_ka_ff;
   logic [3:0][33:0] s3_m1_ff;
   logic [63:0] s3_pd4_ff;

   logic [31:0] s4_ppap_ff, s4_caa_ff, s4_cpr_ff, s4_d1_ff, s4_kr_ff, s4_ka_ff, s4_d4_ff;
   logic [3:0][33:0] s4_m1_ff;
   logic [49:0] s4_pkar_ff;

   pec_pkg::coef_type out_ff;

   always_comb begin
      ce[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int j = NST-2; j >= 0; j--) begin
         ce[j] = !vld_ff[j] || ce[j+1];
      end
   end

   assign in_ready  = ce[0];
   assign out_valid = vld_ff[NST-1];
   assign out_coef  = out_ff;
   assign vld_in    = {vld_ff[NST-2:0], in_valid};

   assign rho_one = 26'(in_rho) + 26'(ONE);
   assign sumc_in = 34'(car_ff[1].rho) + 34'(car_ff[1].alpha) + 34'(ONE) + 34'(s1_ra_ff);
   assign c1_sum  = 33'(s1_cpr_ff) + 33'(ONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int j = 0; j < NST; j++) begin
            if (ce[j]) begin
               vld_ff[j] <= vld_in[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         car_ff[0]  <= '{ints: in_ints, rho: in_rho, pp: in_pp, alpha: in_alpha, ap: in_ap};
         s0_ppap_ff <= in_pp * in_ap;
         s0_caa_ff  <= in_ap * in_alpha;
         s0_cpr_ff  <= in_pp * in_rho;
         s0_ra_ff   <= in_rho * in_alpha;
         s0_d1_ff   <= 44'(in_pp) * 44'(rho_one);
      end
      if (ce[1]) begin
         car_ff[1]  <= car_ff[0];
         s1_ppap_ff <= rnd(64'(s0_ppap_ff));
         s1_caa_ff  <= rnd(64'(s0_caa_ff));
         s1_cpr_ff  <= rnd(64'(s0_cpr_ff));
         s1_ra_ff   <= rnd(64'(s0_ra_ff));
         s1_d1_ff   <= rnd(64'(s0_d1_ff));
      end
      if (ce[2]) begin
         car_ff[2]   <= car_ff[1];
         s2_ppap_ff  <= s1_ppap_ff;
         s2_caa_ff   <= s1_caa_ff;
         s2_cpr_ff   <= s1_cpr_ff;
         s2_d1_ff    <= s1_d1_ff;
         s2_kr_ff    <= 50'(s1_ppap_ff) * 50'(car_ff[1].rho);
         s2_ka_ff    <= 50'(s1_ppap_ff) * 50'(car_ff[1].alpha);
         s2_sumc_ff  <= csat34(sumc_in);
         s2_m1_ff[0] <= 34'((c1_sum > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : c1_sum[31:0]);
         s2_m1_ff[1] <= 34'(car_ff[1].pp) - 34'(ONE);
         s2_m1_ff[2] <= 34'(s1_cpr_ff) - 34'(ONE);
         s2_m1_ff[3] <= 34'(car_ff[1].pp) + 34'(ONE);
      end
      if (ce[3]) begin
         car_ff[3]  <= car_ff[2];
         s3_ppap_ff <= s2_ppap_ff;
         s3_caa_ff  <= s2_caa_ff;
         s3_cpr_ff  <= s2_cpr_ff;
         s3_d1_ff   <= s2_d1_ff;
         s3_m1_ff   <= s2_m1_ff;
         s3_kr_ff   <= rnd(64'(s2_kr_ff));
         s3_ka_ff   <= rnd(64'(s2_ka_ff));
         s3_pd4_ff  <= 64'(s2_ppap_ff) * 64'(s2_sumc_ff);
      end
      if (ce[4]) begin
         car_ff[4]  <= car_ff[3];
         s4_ppap_ff <= s3_ppap_ff;
         s4_caa_ff  <= s3_caa_ff;
         s4_cpr_ff  <= s3_cpr_ff;
         s4_d1_ff   <= s3_d1_ff;
         s4_m1_ff   <= s3_m1_ff;
         s4_kr_ff   <= s3_kr_ff;
         s4_ka_ff   <= s3_ka_ff;
         s4_pkar_ff <= 50'(s3_ka_ff) * 50'(car_ff[3].rho);
         s4_d4_ff   <= rnd(s3_pd4_ff);
      end
      if (ce[5]) begin
         out_ff.ints <= car_ff[4].ints;
         out_ff.ppap <= s4_ppap_ff;
         out_ff.k_r  <= s4_kr_ff;
         out_ff.k_a  <= s4_ka_ff;
         out_ff.k_ar <= rnd(64'(s4_pkar_ff));
         out_ff.pp   <= 32'(car_ff[4].pp);
         out_ff.ap   <= 32'(car_ff[4].ap);
         out_ff.c_aa <= s4_caa_ff;
         out_ff.c_pr <= s4_cpr_ff;
         out_ff.m1_c <= s4_m1_ff;
         out_ff.den  <= (mode == pec_pkg::MODE_TWO) ? s4_d1_ff : s4_d4_ff;
      end
   end

endmodule

/* hdl/pec_num.sv */
// Numerator pipeline: intensity-by-coefficient terms, rounding and channel sums.
// Four register stages; depends on pec_pkg.
module pec_num #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  pec_pkg::mode_type  mode,
   input  logic               in_valid,
   output logic               in_ready,
   input  pec_pkg::coef_type  in_coef,
   output logic               out_valid,
   input  logic               out_ready,
   output pec_pkg::num_type   out_num
);

   localparam int NST  = 4;
   localparam int NPRD = 16;
   localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

   function automatic logic signed [64:0] smul(input logic signed [31:0] a,
                                               input logic signed [33:0] c);
      smul = 65'(a) * 65'(c);
   endfunction

   function automatic logic signed [33:0] ucf(input logic [31:0] c);
      ucf = $signed({2'b00, c});
   endfunction

   function automatic logic signed [63:0] rterm(input logic signed [64:0] p);
      logic signed [64:0] r;
      r = (p + HALF) >>> FRAC_BITS;
      rterm = r[63:0];
   endfunction

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] ce;

   logic signed [64:0] prd_ff [NPRD];
   logic signed [64:0] prd_in [NPRD];
   logic signed [33:0] s0_s_ff, s1_s_ff, s2_s_ff;
   logic [31:0]        s0_den_ff, s1_den_ff, s2_den_ff;
   logic signed [63:0] trm_ff [NPRD];
   logic signed [63:0] a0_ff, u1_ff, u2_ff, u3_ff, u4_ff, m1n0_ff, m1n3_ff;
   pec_pkg::num_type   out_ff;
   logic signed [63:0] s64;

   always_comb begin
      ce[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int j = NST-2; j >= 0; j--) begin
         ce[j] = !vld_ff[j] || ce[j+1];
      end
   end

   assign in_ready  = ce[0];
   assign out_valid = vld_ff[NST-1];
   assign out_num   = out_ff;
   assign s64       = 64'(s2_s_ff);
   assign vld_in    = {vld_ff[NST-2:0], in_valid};

   always_comb begin
      prd_in[0]  = smul(in_coef.ints.int_aa, ucf(in_coef.ppap));
      prd_in[1]  = smul(in_coef.ints.int_pa, ucf(in_coef.k_r));
      prd_in[2]  = smul(in_coef.ints.int_ap, ucf(in_coef.k_a));
      prd_in[3]  = smul(in_coef.ints.int_pp, ucf(in_coef.k_ar));
      prd_in[4]  = smul(in_coef.ints.int_aa, ucf(in_coef.pp));
      prd_in[5]  = smul(in_coef.ints.int_ap, ucf(in_coef.pp));
      prd_in[6]  = smul(in_coef.ints.int_aa, ucf(in_coef.ap));
      prd_in[7]  = smul(in_coef.ints.int_pa, ucf(in_coef.ap));
      prd_in[8]  = smul(in_coef.ints.int_pp, ucf(in_coef.c_aa));
      prd_in[9]  = smul(in_coef.ints.int_ap, ucf(in_coef.c_aa));
      prd_in[10] = smul(in_coef.ints.int_pp, ucf(in_coef.c_pr));
      prd_in[11] = smul(in_coef.ints.int_pa, ucf(in_coef.c_pr));
      prd_in[12] = smul(in_coef.ints.int_pp, $signed(in_coef.m1_c[0]));
      prd_in[13] = smul(in_coef.ints.int_aa, $signed(in_coef.m1_c[1]));
      prd_in[14] = smul(in_coef.ints.int_pp, $signed(in_coef.m1_c[2]));
      prd_in[15] = smul(in_coef.ints.int_aa, $signed(in_coef.m1_c[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int j = 0; j < NST; j++) begin
            if (ce[j]) begin
               vld_ff[j] <= vld_in[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         for (int i = 0; i < NPRD; i++) begin
            prd_ff[i] <= prd_in[i];
         end
         s0_s_ff   <= 34'(in_coef.ints.int_pp) + 34'(in_coef.ints.int_aa)
                    - 34'(in_coef.ints.int_pa) - 34'(in_coef.ints.int_ap);
         s0_den_ff <= in_coef.den;
      end
      if (ce[1]) begin
         for (int i = 0; i < NPRD; i++) begin
            trm_ff[i] <= rterm(prd_ff[i]);
         end
         s1_s_ff   <= s0_s_ff;
         s1_den_ff <= s0_den_ff;
      end
      if (ce[2]) begin
         a0_ff     <= trm_ff[0] + trm_ff[1] + trm_ff[2] + trm_ff[3];
         u1_ff     <= trm_ff[4] - trm_ff[5];
         u2_ff     <= trm_ff[6] - trm_ff[7];
         u3_ff     <= trm_ff[8] - trm_ff[9];
         u4_ff     <= trm_ff[10] - trm_ff[11];
         m1n0_ff   <= trm_ff[12] + trm_ff[13];
         m1n3_ff   <= trm_ff[14] + trm_ff[15];
         s2_s_ff   <= s1_s_ff;
         s2_den_ff <= s1_den_ff;
      end
      if (ce[3]) begin
         out_ff.den <= s2_den_ff;
         if (mode == pec_pkg::MODE_TWO) begin
            out_ff.num[0] <= m1n0_ff;
            out_ff.num[1] <= '0;
            out_ff.num[2] <= '0;
            out_ff.num[3] <= m1n3_ff;
         end else begin
            out_ff.num[0] <= a0_ff - u1_ff - u2_ff + u3_ff + u4_ff + s64;
            out_ff.num[1] <= a0_ff + u1_ff - u2_ff + u3_ff - u4_ff - s64;
            out_ff.num[2] <= a0_ff - u1_ff + u2_ff - u3_ff + u4_ff - s64;
            out_ff.num[3] <= a0_ff + u1_ff + u2_ff - u3_ff - u4_ff + s64;
         end
      end
   end

endmodule

/* hdl/pec_div.sv */
// Shared-denominator divider: four lanes of restoring division, one quotient bit per stage,
// with rounding, saturation and the zero-denominator case. Depends on pec_pkg.
module pec_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pec_pkg::mode_type        mode,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pec_pkg::num_type         in_num,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [3:0][31:0]         out_corr,
   output logic                     out_zero,
   output logic                     out_sat
);

   localparam int QW  = 32;
   localparam int XW  = 70;
   localparam int NST = QW + 3;

   typedef struct packed {
      logic        neg;
      logic        ovf;
      logic [32:0] rem;
      logic [31:0] xlo;
      logic [31:0] quo;
   } lane_type;

   typedef struct packed {
      lane_type [3:0] ln;
      logic [32:0]    dv;
      logic           zero;
   } dstage_type;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] ce;

   logic [3:0]          p_neg_ff;
   logic [3:0][XW-1:0]  p_x_ff;
   logic [32:0]         p_dv_ff;
   logic                p_zero_ff;

   dstage_type dst_ff [0:QW];
   dstage_type dst_in [0:QW];

   logic [3:0][31:0] corr_ff;
   logic             zero_ff;
   logic             sat_ff;
   logic [3:0][31:0] corr_in;
   logic [3:0]       lsat;

   always_comb begin
      ce[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int j = NST-2; j >= 0; j--) begin
         ce[j] = !vld_ff[j] || ce[j+1];
      end
   end

   assign in_ready  = ce[0];
   assign out_valid = vld_ff[NST-1];
   assign out_corr  = corr_ff;
   assign out_zero  = zero_ff;
   assign out_sat   = sat_ff;
   assign vld_in    = {vld_ff[NST-2:0], in_valid};

   // quotient overflow check and initial remainder, then one bit per stage
   always_comb begin
      dst_in[0].dv   = p_dv_ff;
      dst_in[0].zero = p_zero_ff;
      for (int l = 0; l < 4; l++) begin
         dst_in[0].ln[l].neg = p_neg_ff[l];
         dst_in[0].ln[l].ovf = p_x_ff[l][XW-1:QW] >= 38'(p_dv_ff);
         dst_in[0].ln[l].rem = p_x_ff[l][QW+32:QW];
         dst_in[0].ln[l].xlo = p_x_ff[l][QW-1:0];
         dst_in[0].ln[l].quo = '0;
      end
      for (int k = 1; k <= QW; k++) begin
         dst_in[k] = dst_ff[k-1];
         for (int l = 0; l < 4; l++) begin
            logic [33:0] rs;
            logic        ge;
            rs = {dst_ff[k-1].ln[l].rem, dst_ff[k-1].ln[l].xlo[QW-1]};
            ge = rs >= {1'b0, dst_ff[k-1].dv};
            dst_in[k].ln[l].rem = ge ? 33'(rs - {1'b0, dst_ff[k-1].dv}) : rs[32:0];
            dst_in[k].ln[l].xlo = {dst_ff[k-1].ln[l].xlo[QW-2:0], 1'b0};
            dst_in[k].ln[l].quo = {dst_ff[k-1].ln[l].quo[QW-2:0], ge};
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lane_type lv;
         lv = dst_ff[QW].ln[l];
         lsat[l]    = 1'b0;
         corr_in[l] = '0;
         if (dst_ff[QW].zero) begin
            corr_in[l] = '0;
         end else if (mode == pec_pkg::MODE_TWO && (l == 1 || l == 2)) begin
            corr_in[l] = '0;
         end else if (!lv.neg) begin
            if (lv.ovf || lv.quo[QW-1]) begin
               lsat[l]    = 1'b1;
               corr_in[l] = 32'h7FFF_FFFF;
            end else begin
               corr_in[l] = lv.quo;
            end
         end else begin
            if (lv.ovf || lv.quo > 32'h8000_0000) begin
               lsat[l]    = 1'b1;
               corr_in[l] = 32'h8000_0000;
            end else begin
               corr_in[l] = 32'(0) - lv.quo;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int j = 0; j < NST; j++) begin
            if (ce[j]) begin
               vld_ff[j] <= vld_in[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         for (int l = 0; l < 4; l++) begin
            logic [63:0] m;
            m = in_num.num[l][63] ? (64'(0) - in_num.num[l]) : in_num.num[l];
            p_neg_ff[l] <= in_num.num[l][63];
            p_x_ff[l]   <= (XW'(m) << (FRAC_BITS + 1)) + XW'(in_num.den);
         end
         p_dv_ff   <= {in_num.den, 1'b0};
         p_zero_ff <= (in_num.den == '0);
      end
      for (int k = 0; k <= QW; k++) begin
         if (ce[k+1]) begin
            dst_ff[k] <= dst_in[k];
         end
      end
      if (ce[NST-1]) begin
         corr_ff <= corr_in;
         zero_ff <= dst_ff[QW].zero;
         sat_ff  <= |lsat;
      end
   end

endmodule

/* hdl/polarization_efficiency_correct.sv */
// Polarization efficiency correction, one wavelength bin per beat.
// Channels: req_* carries measured intensities and efficiency factors of a bin, rsp_* the
// corrected intensities with a zero-denominator flag and a saturation flag. csr_wen/csr_wdata
// write the analysis mode (0 four-channel, 1 two-channel); write it only while idle.
// Throughput: one bin per cycle, every cycle, as long as rsp_tready stays high.
// Pipeline from req accept to rsp_tvalid: 6 coefficient stages, 4 numerator stages, and 35
// divider stages (one quotient bit per stage across 32 stages, plus setup and output).
// Reset: all stage valid bits clear, mode goes to four-channel, rsp_tvalid drops.
// Stall: with rsp_tready low, the result holds in the output register; upstream stages
// keep advancing into empty slots, so req_tready stays high until the pipeline is full.
// Depends on pec_pkg, pec_coef, pec_num and pec_div.
module polarization_efficiency_correct #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // int_pp, int_pa, int_ap, int_aa (32 each), eff_rho, eff_pp, eff_alpha, eff_ap (18 each)
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // corr_pp, corr_pa, corr_ap, corr_aa (32 each), zero_denominator, saturated, 6 zero bits
   output logic [135:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic         csr_wdata
);

   pec_pkg::mode_type   mode_ff;
   pec_pkg::intens_type ints;
   pec_pkg::coef_type   coef;
   pec_pkg::num_type    num;
   logic                coef_valid, coef_ready;
   logic                num_valid, num_ready;
   logic [3:0][31:0]    corr;
   logic                zero_den, sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pec_pkg::MODE_FULL;
      end else if (csr_wen) begin
         mode_ff <= pec_pkg::mode_type'(csr_wdata);
      end
   end

   assign ints.int_pp = req_tdata[31:0];
   assign ints.int_pa = req_tdata[63:32];
   assign ints.int_ap = req_tdata[95:64];
   assign ints.int_aa = req_tdata[127:96];

   pec_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ints   (ints),
      .in_rho    (req_tdata[145:128]),
      .in_pp     (req_tdata[163:146]),
      .in_alpha  (req_tdata[181:164]),
      .in_ap     (req_tdata[199:182]),
      .out_valid (coef_valid),
      .out_ready (coef_ready),
      .out_coef  (coef)
   );

   pec_num #(.FRAC_BITS(FRAC_BITS)) u_num (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (coef_valid),
      .in_ready  (coef_ready),
      .in_coef   (coef),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_num   (num)
   );

   pec_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_num    (num),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_corr  (corr),
      .out_zero  (zero_den),
      .out_sat   (sat)
   );

   assign rsp_tdata = {6'b0, sat, zero_den, corr};

`ifndef SYNTHESIS
   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && zero_den |-> corr == '0 && !sat)
      else $error("zero denominator beat carries nonzero data or saturation");

   a_two_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mode_ff == pec_pkg::MODE_TWO |-> corr[1] == '0 && corr[2] == '0)
      else $error("two-channel beat carries nonzero pa or ap");

   a_empty_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output register is empty");
`endif

endmodule
